[design/dtlr_pkg.sv]
// shared constants for the depth tested line rasterizer
// no dependencies
package dtlr_pkg;
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int DEPTH_BITS = 16;
  localparam logic [1:0] OP_LINE  = 2'd0;
  localparam logic [1:0] OP_PLOT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
endpackage

[design/dtlr_divider.sv]
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on nothing
module dtlr_divider #(
  parameter int NW = 36,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0] rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic busy;
  logic [DW:0] shifted;
  logic [DW:0] diff;

  assign shifted = {rem[DW-1:0], q[NW-1]};
  assign diff = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        rem <= '0;
        d <= den;
        cnt <= CW'(NW);
      end else if (busy) begin
        if (!diff[DW]) begin
          rem <= diff;
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
endmodule

[design/depth_tested_line_rasterizer.sv]
// depth tested line rasterizer: sequencer, shared divider, color/depth stores
// depends on dtlr_pkg and dtlr_divider
// plot/read access one pixel without the divider, clear walks every store location, line
// runs three divisions (x, y, depth) per pixel on the one divider, none when steps is 0
// one request at a time, the next accepted the cycle after the result is taken
// reset: stores run a clearing pass over all MAX_WIDTH*MAX_HEIGHT locations, no request taken meanwhile
module depth_tested_line_rasterizer #(
  parameter int MAX_WIDTH  = dtlr_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = dtlr_pkg::MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0] start_x[17:2] start_y[33:18] start_depth[51:34] end_x[67:52]
  // end_y[83:68] end_depth[101:84] pixel_color[133:102]
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_color[31:0] read_depth[48:32] pixels_written[65:49]
  output logic [71:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int ZW = dtlr_pkg::DEPTH_BITS + 1;
  localparam logic [ZW-1:0] ZINF = '1;
  localparam logic [ZW-1:0] ZONE = ZW'((1 << dtlr_pkg::DEPTH_BITS) - 1);

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_SETUP = 4'd2,
    S_DX = 4'd3, S_DY = 4'd4, S_DZ = 4'd5, S_PIX = 4'd6, S_RD = 4'd7,
    S_CMP = 4'd8, S_OUT = 4'd9, S_CLR = 4'd10, S_DIVW = 4'd11;

  logic [3:0] state;
  logic [7:0] reg_w, reg_h;
  logic [1:0] op;
  logic signed [17:0] x0, y0, x1, y1;
  logic signed [18:0] z0, z1;
  logic [31:0] color;
  logic [16:0] steps, i;
  logic [16:0] count;
  logic signed [35:0] xq, yq, zq;
  logic [AW:0] caddr;
  logic [AW-1:0] addr;
  logic in_frame, is_read;
  logic [31:0] rc;
  logic [ZW-1:0] rd, zc;
  logic [31:0] color_mem [SIZE];
  logic [ZW-1:0] depth_mem [SIZE];
  logic [31:0] cm_q;
  logic [ZW-1:0] dm_q;

  // effective frame size
  logic [12:0] ew, eh;
  always_comb begin
    ew = (reg_w == 8'd0) ? 13'd1 : ((13'(reg_w) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(reg_w));
    eh = (reg_h == 8'd0) ? 13'd1 : ((13'(reg_h) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(reg_h));
  end

  assign pready = 1'b1;
  always_comb begin
    unique case ({1'b0, paddr[2]})
      dtlr_pkg::REG_WIDTH: prdata = {24'd0, reg_w};
      default:             prdata = {24'd0, reg_h};
    endcase
  end

  // shared divider operands: magnitude of numerator, with sign kept aside
  logic div_start, div_done, neg;
  logic [35:0] div_num, div_quo;
  logic [1:0] dsel;
  logic signed [17:0] dx, dy;
  logic signed [18:0] dz;
  assign dx = x1 - x0;
  assign dy = y1 - y0;
  assign dz = z1 - z0;

  logic signed [36:0] prod;
  logic signed [18:0] mul_a;
  logic signed [17:0] mul_b;
  always_comb begin
    case (dsel)
      2'd0: mul_a = 19'(dx);
      2'd1: mul_a = 19'(dy);
      default: mul_a = dz;
    endcase
    mul_b = $signed({1'b0, i});
    prod = 37'(mul_a * mul_b);
  end
  logic signed [36:0] base;
  always_comb begin
    case (dsel)
      2'd0: base = 37'(x0 * $signed({1'b0, steps}));
      2'd1: base = 37'(y0 * $signed({1'b0, steps}));
      default: base = '0;
    endcase
  end
  logic signed [36:0] num_reg;
  logic [17:0] den_v;
  dtlr_divider #(.NW(36), .DW(18)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(den_v),
    .done(div_done), .quo(div_quo)
  );

  // rounding: x/y use (2|n|+s)/(2s), z uses |n|/s
  always_comb begin
    if (dsel == 2'd2) begin
      div_num = 36'(num_reg[36] ? -num_reg : num_reg);
      den_v = {1'b0, steps};
    end else begin
      div_num = 36'(((num_reg[36] ? -num_reg : num_reg) <<< 1) + 37'(steps));
      den_v = {steps, 1'b0};
    end
  end

  logic signed [36:0] qs;
  assign qs = neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  // clamp pixel
  logic signed [35:0] cx, cy;
  logic signed [36:0] cz;
  always_comb begin
    cx = (xq < 0) ? 36'sd0 : ((xq > 36'(ew) - 1) ? 36'(ew) - 1 : xq);
    cy = (yq < 0) ? 36'sd0 : ((yq > 36'(eh) - 1) ? 36'(eh) - 1 : yq);
    cz = 37'(zq) + 37'(z0);
  end
  logic [ZW-1:0] zsat;
  always_comb begin
    if (cz < 0) zsat = '0;
    else if (cz > 37'(ZONE)) zsat = ZONE;
    else zsat = ZW'(cz);
  end

  logic [25:0] lin;
  assign lin = 26'(cy[12:0] * ew) + 26'(cx[12:0]);

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_INIT || state == S_CLR) begin
      color_mem[caddr[AW-1:0]] <= color;
      depth_mem[caddr[AW-1:0]] <= ZINF;
    end else if (state == S_CMP && in_frame && !is_read && zc < dm_q) begin
      color_mem[addr] <= color;
      depth_mem[addr] <= zc;
    end
    cm_q <= color_mem[addr];
    dm_q <= depth_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      caddr <= '0;
      color <= '0;
      reg_w <= 8'd128;
      reg_h <= 8'd128;
      m_tvalid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (psel && penable && pwrite) begin
        if ({1'b0, paddr[2]} == dtlr_pkg::REG_WIDTH) reg_w <= pwdata[7:0];
        else if ({1'b0, paddr[2]} == dtlr_pkg::REG_HEIGHT) reg_h <= pwdata[7:0];
      end
      unique case (state) inside
        S_INIT, S_CLR: begin
          caddr <= caddr + 1'b1;
          if (caddr == (AW+1)'(SIZE - 1)) state <= (state == S_INIT) ? S_IDLE : S_OUT;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tdata[1:0];
            x0 <= 18'($signed(s_tdata[17:2]));
            y0 <= 18'($signed(s_tdata[33:18]));
            z0 <= 19'($signed(s_tdata[51:34]));
            x1 <= 18'($signed(s_tdata[67:52]));
            y1 <= 18'($signed(s_tdata[83:68]));
            z1 <= 19'($signed(s_tdata[101:84]));
            color <= s_tdata[133:102];
            count <= '0;
            i <= '0;
            rc <= '0;
            rd <= '0;
            caddr <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          unique case (op)
            dtlr_pkg::OP_CLEAR: state <= S_CLR;
            dtlr_pkg::OP_LINE: begin
              steps <= 17'(((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy) ?
                           ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy));
              state <= S_DX;
              dsel <= 2'd0;
            end
            default: begin
              xq <= 36'(x0);
              yq <= 36'(y0);
              zq <= '0;
              is_read <= (op == dtlr_pkg::OP_READ);
              state <= S_PIX;
            end
          endcase
        end
        S_DX, S_DY, S_DZ: begin
          if (steps == '0) begin
            xq <= 36'(x0);
            yq <= 36'(y0);
            zq <= '0;
            is_read <= 1'b0;
            state <= S_PIX;
          end else begin
            num_reg <= base + prod;
            neg <= (base + prod) < 0;
            div_start <= 1'b1;
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            unique case (dsel)
              2'd0: begin xq <= 36'(qs); dsel <= 2'd1; state <= S_DY; end
              2'd1: begin yq <= 36'(qs); dsel <= 2'd2; state <= S_DZ; end
              default: begin
                zq <= 36'(qs);
                dsel <= 2'd0;
                is_read <= 1'b0;
                state <= S_PIX;
              end
            endcase
          end
        end
        S_PIX: begin
          if (is_read || op == dtlr_pkg::OP_PLOT) begin
            in_frame <= (xq >= 0) && (xq < 36'(ew)) && (yq >= 0) && (yq < 36'(eh));
            addr <= AW'(26'(yq[12:0] * ew) + 26'(xq[12:0]));
          end else begin
            in_frame <= 1'b1;
            addr <= AW'(lin);
          end
          zc <= zsat;
          state <= S_RD;
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (is_read) begin
            rc <= in_frame ? cm_q : 32'd0;
            rd <= in_frame ? dm_q : ZINF;
            state <= S_OUT;
          end else begin
            if (in_frame && zc < dm_q) count <= count + 1'b1;
            if (op == dtlr_pkg::OP_LINE && i != steps) begin
              i <= i + 1'b1;
              state <= S_DX;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= {6'd0, count, rd, rc};
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while result pending");
  a_count_zero_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && op == dtlr_pkg::OP_READ) |-> m_tdata[65:49] == 17'd0)
    else $error("read reports writes");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_DIVW) else $error("divider started outside wait");
`endif
endmodule

[dv/depth_tested_line_rasterizer_test.sv]
// self-checking bench for depth_tested_line_rasterizer: directed table, then random phases
// predicts color, depth and pixel counts with its own frame model; depends on dtlr_pkg and depth_tested_line_rasterizer
module depth_tested_line_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_SIZE = dtlr_pkg::MAX_WIDTH * dtlr_pkg::MAX_HEIGHT;
  localparam longint DEPTH_ONE = (64'd1 << dtlr_pkg::DEPTH_BITS) - 1;
  localparam logic [16:0] DEPTH_INF = 17'h1FFFF;
  localparam int IDLE_LIMIT = 100000;

  typedef struct {
    logic [1:0]  op;
    int          sx, sy, sz, ex, ey, ez;
    logic [31:0] color;
  } raster_cmd_t;

  typedef struct {
    logic [31:0] rc;
    logic [16:0] rd;
    logic [16:0] pw;
  } raster_result_t;

  typedef struct {
    raster_cmd_t    cmd;
    bit             typed;
    raster_result_t res;
  } table_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  logic [31:0]    frame_color [STORE_SIZE];
  logic [16:0]    frame_depth [STORE_SIZE];
  logic [7:0]     width_reg, height_reg;
  raster_result_t pending_results[$];
  table_row_t     directed_rows[$];
  int             failures = 0;
  int             idle_cycles = 0;
  bit             hold_request = 0;
  bit             cfg_done = 0;

  depth_tested_line_rasterizer uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > dtlr_pkg::MAX_WIDTH) return dtlr_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic longint frame_h();
    if (height_reg == 0) return 1;
    if (height_reg > dtlr_pkg::MAX_HEIGHT) return dtlr_pkg::MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint round_away(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic int depth_tested_write(longint x, longint y, longint z,
                                            logic [31:0] color);
    longint idx;
    z = clamp_to(z, 0, DEPTH_ONE);
    if (x < 0 || x >= frame_w() || y < 0 || y >= frame_h()) return 0;
    idx = y * frame_w() + x;
    if (idx >= STORE_SIZE) return 0;
    if (z < frame_depth[idx]) begin
      frame_depth[idx] = z[16:0];
      frame_color[idx] = color;
      return 1;
    end
    return 0;
  endfunction

  function automatic raster_result_t predict_command(raster_cmd_t c);
    raster_result_t r;
    longint dx, dy, dz, steps, x, y, z, idx;
    r.rc = '0;
    r.rd = '0;
    r.pw = '0;
    case (c.op)
      dtlr_pkg::OP_LINE: begin
        dx = c.ex - c.sx;
        dy = c.ey - c.sy;
        dz = c.ez - c.sz;
        steps = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                          : (dy < 0 ? -dy : dy);
        for (longint i = 0; i <= steps; i++) begin
          if (steps > 0) begin
            x = round_away(c.sx * steps + dx * i, steps);
            y = round_away(c.sy * steps + dy * i, steps);
            z = c.sz + (dz * i) / steps;
          end else begin
            x = c.sx;
            y = c.sy;
            z = c.sz;
          end
          x = clamp_to(x, 0, frame_w() - 1);
          y = clamp_to(y, 0, frame_h() - 1);
          r.pw = r.pw + 17'(depth_tested_write(x, y, z, c.color));
        end
      end
      dtlr_pkg::OP_PLOT: r.pw = 17'(depth_tested_write(c.sx, c.sy, c.sz, c.color));
      dtlr_pkg::OP_CLEAR: begin
        for (int i = 0; i < STORE_SIZE; i++) begin
          frame_color[i] = c.color;
          frame_depth[i] = DEPTH_INF;
        end
      end
      default: begin
        r.rd = DEPTH_INF;
        if (c.sx >= 0 && c.sx < frame_w() && c.sy >= 0 && c.sy < frame_h()) begin
          idx = c.sy * frame_w() + c.sx;
          if (idx < STORE_SIZE) begin
            r.rc = frame_color[idx];
            r.rd = frame_depth[idx];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void expect_result(raster_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row(table_row_t t);
    directed_rows.insert(directed_rows.size(), t);
  endfunction

  // drives one request and waits for it to be taken; the edge that takes it returns
  task automatic send_command(raster_cmd_t c, bit typed, raster_result_t res);
    raster_result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, c.color, c.ez[17:0], c.ey[15:0], c.ex[15:0], c.sz[17:0],
                 c.sy[15:0], c.sx[15:0], c.op};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    r = predict_command(c);
    expect_result(typed ? res : r);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 1'b0} << 1;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (index == dtlr_pkg::REG_WIDTH) width_reg = value[7:0];
    else if (index == dtlr_pkg::REG_HEIGHT) height_reg = value[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_done = 1;
  endtask

  function automatic int pick_coord(longint lim);
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, lim + 4)) - 2;
    return int'(shortint'($urandom_range(0, 65535)));
  endfunction

  function automatic int pick_depth();
    int k;
    k = $urandom_range(0, 9);
    if (k < 8) return $urandom_range(0, 65535);
    if (k == 8) return $urandom_range(65536, 131071);
    return -int'($urandom_range(1, 131072));
  endfunction

  function automatic int line_end(int s, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    if (s + d > 32767 || s + d < -32768) d = -d;
    return s + d;
  endfunction

  function automatic raster_cmd_t random_command();
    raster_cmd_t c;
    int k, span;
    k = $urandom_range(0, 99);
    c.op = k < 40 ? dtlr_pkg::OP_LINE : k < 65 ? dtlr_pkg::OP_PLOT :
           k < 99 ? dtlr_pkg::OP_READ : dtlr_pkg::OP_CLEAR;
    c.sx = pick_coord(frame_w());
    c.sy = pick_coord(frame_h());
    c.sz = pick_depth();
    c.ez = pick_depth();
    c.color = $urandom();
    span = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(0, 10);
    c.ex = line_end(c.sx, span);
    c.ey = line_end(c.sy, span);
    if (c.op != dtlr_pkg::OP_LINE && $urandom_range(0, 1)) begin
      c.ex = int'(shortint'($urandom_range(0, 65535)));
      c.ey = int'(shortint'($urandom_range(0, 65535)));
    end
    return c;
  endfunction

  function automatic table_row_t row(logic [1:0] op, int sx, int sy, int sz, int ex, int ey,
                                     int ez, logic [31:0] color, bit typed = 0,
                                     logic [31:0] rc = 0, logic [16:0] rd = 0,
                                     logic [16:0] pw = 0);
    table_row_t t;
    t.cmd = '{op, sx, sy, sz, ex, ey, ez, color};
    t.typed = typed;
    t.res = '{rc, rd, pw};
    return t;
  endfunction

  // receiver: stall pattern re-picked at random from three modes, long hold-off on request
  always @(posedge clk) begin : receiver
    static int mode = 0;
    static int tick = 0;
    static int hold = 0;
    if (hold_request && hold == 0) begin
      hold = 3000;
      hold_request = 0;
    end
    tick++;
    if (tick % 64 == 0) mode = $urandom_range(0, 2);
    if (hold > 0) begin
      hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= mode == 0 ? 1'b1 : mode == 1 ? ($urandom_range(0, 3) != 0)
                                               : ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin : result_check
    raster_result_t want;
    if (m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: %h", m_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.rc) begin
          $error("read_color expected %h got %h", want.rc, m_tdata[31:0]);
          failures++;
        end
        if (m_tdata[48:32] !== want.rd) begin
          $error("read_depth expected %0d got %0d", want.rd, m_tdata[48:32]);
          failures++;
        end
        if (m_tdata[65:49] !== want.pw) begin
          $error("pixels_written expected %0d got %0d", want.pw, m_tdata[65:49]);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_done) idle_cycles = 0;
    else idle_cycles++;
    cfg_done = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int widths[7] = '{128, 1, 0, 37, 255, 128, 3};
    int heights[7] = '{128, 1, 0, 5, 200, 1, 128};
    raster_result_t none;
    int left;
    none = '{0, 0, 0};
    width_reg = 128;
    height_reg = 128;
    for (int i = 0; i < STORE_SIZE; i++) begin
      frame_color[i] = '0;
      frame_depth[i] = DEPTH_INF;
    end

    add_row(row(dtlr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, DEPTH_INF, 0));
    add_row(row(dtlr_pkg::OP_READ, 127, 127, 0, 0, 0, 0, 0, 1, 0, DEPTH_INF, 0));
    add_row(row(dtlr_pkg::OP_READ, -32768, 32767, 0, 0, 0, 0, 0, 1, 0, DEPTH_INF, 0));
    add_row(row(dtlr_pkg::OP_READ, 128, 0, 0, 0, 0, 0, 0, 1, 0, DEPTH_INF, 0));
    add_row(row(dtlr_pkg::OP_PLOT, 128, 5, 10, 0, 0, 0, 32'h1, 1, 0, 0, 0));
    add_row(row(dtlr_pkg::OP_PLOT, -1, 5, 10, 0, 0, 0, 32'h1, 1, 0, 0, 0));
    add_row(row(dtlr_pkg::OP_PLOT, 0, 0, 100, 0, 0, 0, 32'hFFFFFFFF, 1, 0, 0, 1));
    add_row(row(dtlr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 32'hFFFFFFFF, 100, 0));
    add_row(row(dtlr_pkg::OP_PLOT, 0, 0, 100, 0, 0, 0, 32'h5, 1, 0, 0, 0));
    add_row(row(dtlr_pkg::OP_PLOT, 1, 0, -131072, 0, 0, 0, 32'hA5A5A5A5, 1, 0, 0, 1));
    add_row(row(dtlr_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 1, 32'hA5A5A5A5, 0, 0));
    add_row(row(dtlr_pkg::OP_PLOT, 2, 0, 131071, 0, 0, 0, 32'h5A5A5A5A, 1, 0, 0, 1));
    add_row(row(dtlr_pkg::OP_READ, 2, 0, 0, 0, 0, 0, 0, 1, 32'h5A5A5A5A,
                DEPTH_ONE[16:0], 0));
    add_row(row(dtlr_pkg::OP_LINE, 10, 10, 500, 10, 10, 900, 32'h00FF0000));
    add_row(row(dtlr_pkg::OP_LINE, 0, 3, 0, 4, 5, 65535, 32'h0000FF00));
    add_row(row(dtlr_pkg::OP_LINE, 9, 1, 131071, 5, 0, -131072, 32'h000000FF));
    add_row(row(dtlr_pkg::OP_LINE, -32768, 32767, 7, -32765, 32764, 3, 32'h12345678));
    add_row(row(dtlr_pkg::OP_LINE, 32767, -32768, 70000, 32763, -32766, -5,
                32'h87654321));
    add_row(row(dtlr_pkg::OP_READ, 4, 5, 0, 0, 0, 0, 0));
    add_row(row(dtlr_pkg::OP_READ, 127, 0, 0, 0, 0, 0, 0));
    add_row(row(dtlr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 32'hDEADBEEF, 1, 0, 0, 0));
    add_row(row(dtlr_pkg::OP_READ, 127, 127, 0, 0, 0, 0, 0, 1, 32'hDEADBEEF,
                DEPTH_INF, 0));
    add_row(row(dtlr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 32'hDEADBEEF, DEPTH_INF, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_reg(dtlr_pkg::REG_WIDTH, 128);
    write_reg(dtlr_pkg::REG_HEIGHT, 128);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
      gap($urandom_range(0, 3));
    end
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(dtlr_pkg::REG_WIDTH, widths[p]);
      write_reg(dtlr_pkg::REG_HEIGHT, heights[p]);
      if (p == 1) hold_request = 1;
      left = 0;
      for (int n = 0; n < 200; n++) begin
        if (left == 0) begin
          gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
          left = $urandom_range(1, 12);
        end
        left--;
        if (n == 100 && p == 3) drain();
        send_command(random_command(), 0, none);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[files.f]
design/dtlr_pkg.sv
design/dtlr_divider.sv
design/depth_tested_line_rasterizer.sv
dv/depth_tested_line_rasterizer_test.sv
